### rtl/core/pfd_pkg.sv
// pfd_pkg: constants, band codes and the cell word type for the
// fractional-N divider calculation pipeline. No dependencies.
package pfd_pkg;

	localparam int FRAC_BITS = 20;
	localparam int INT_BITS  = 7;

	localparam int FREQ_W    = 32;
	// Quotient bits taken from the low dividend bits; the top 24 bits are
	// always below the reference, so they preload the remainder directly.
	localparam int INT_STEPS = 8;
	localparam int PRE_BITS  = FREQ_W - INT_STEPS;
	localparam int REM_W     = 25;
	localparam int WORD_W    = INT_STEPS + FRAC_BITS;
	localparam int CELL_CNT  = WORD_W;

	localparam logic [31:0] REF_HZ    = 32'd30000000;
	localparam logic [31:0] EDGE_A    = 32'd2400000000;
	localparam logic [31:0] EDGE_B    = 32'd2500000000;
	localparam logic [31:0] EDGE_C    = 32'd2600000000;
	localparam logic [31:0] ROUND_ADD = REF_HZ >> 21;

	localparam logic [INT_STEPS-1:0] INT_MASK = INT_STEPS'((1 << INT_BITS) - 1);

	localparam logic [1:0] BAND_LOW  = 2'd0;
	localparam logic [1:0] BAND_MID  = 2'd1;
	localparam logic [1:0] BAND_HIGH = 2'd2;
	localparam logic [1:0] BAND_TOP  = 2'd3;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [WORD_W-1:0] word;   // dividend bits still to shift in, quotient bits shift out
		logic [1:0]        band;
		logic              lna;
	} cell_t;

endpackage

### rtl/core/pll_fractional_divider_calc.sv
// pll_fractional_divider_calc: top level, front stage, chain of division
// cells and output register. Depends on pfd_pkg, pfd_front, pfd_cell.
//
// Usage:
//   Input channel: in_valid / in_stall with freq_hz, a target frequency in Hz.
//   Output channel: out_valid / out_stall with band_code, lna_hi,
//   int_divider, frac_high and frac_low. Each input word yields one output
//   word, in order.
//   The pipeline is one front stage (band select, +14 Hz rounding),
//   28 division cells (8 integer quotient bits, 20 fraction bits, one bit
//   per cell against the 30 MHz reference) and the output register.
//   Throughput is one word per cycle while the output is not stalled;
//   each cell holds one word and passes it on when the next is ready.
//   Stall: every stage advances when its successor is empty or advancing,
//   so bubbles collapse and input words are taken while a result waits at
//   the output. in_stall rises only once every stage holds a word and
//   out_stall is high. A stalled output word holds steady.
//   Reset (arst_n low) empties all stages; payload registers are not reset.
module pll_fractional_divider_calc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] freq_hz,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  band_code,
	output logic        lna_hi,
	output logic [6:0]  int_divider,
	output logic [9:0]  frac_high,
	output logic [9:0]  frac_low
);

	localparam int N = pfd_pkg::CELL_CNT;

	// Stage 0 is the front; stages 1..N are the cells
	logic           valid_c [N+1];
	pfd_pkg::cell_t data_c  [N+1];
	logic           ready_c [N+1];
	logic           out_ready;

	logic [pfd_pkg::INT_STEPS-1:0] quot;
	logic [pfd_pkg::FRAC_BITS-1:0] frac;
	logic [19:0]                   frac_ext;

	pfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.freq_hz  (freq_hz),
		.ready_up (ready_c[0]),
		.ready_dn (ready_c[1]),
		.valid_q  (valid_c[0]),
		.data_q   (data_c[0])
	);

	assign in_stall = !ready_c[0];

	for (genvar k = 1; k <= N; k++) begin : g_cell
		logic ready_next;
		if (k == N) begin : g_last
			assign ready_next = out_ready;
		end else begin : g_mid
			assign ready_next = ready_c[k+1];
		end
		pfd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_c[k-1]),
			.in_data  (data_c[k-1]),
			.ready_up (ready_c[k]),
			.ready_dn (ready_next),
			.valid_q  (valid_c[k]),
			.data_q   (data_c[k])
		);
	end

	// Final word: integer quotient on top, fraction bits below
	assign quot     = data_c[N].word[pfd_pkg::WORD_W-1 -: pfd_pkg::INT_STEPS];
	assign frac     = data_c[N].word[pfd_pkg::FRAC_BITS-1:0];
	assign frac_ext = 20'(frac);

	assign out_ready = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= valid_c[N];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_c[N]) begin
			band_code   <= data_c[N].band;
			lna_hi      <= data_c[N].lna;
			int_divider <= 7'(quot & pfd_pkg::INT_MASK);
			frac_high   <= frac_ext[19:10];
			frac_low    <= frac_ext[9:0];
		end
	end

endmodule

### rtl/core/pfd_front.sv
// pfd_front: input stage. Band select, rounding add and remainder preload.
// Depends on pfd_pkg.
module pfd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [pfd_pkg::FREQ_W-1:0]  freq_hz,
	output logic                        ready_up,
	input  logic                        ready_dn,
	output logic                        valid_q,
	output pfd_pkg::cell_t              data_q
);

	logic [pfd_pkg::FREQ_W-1:0] f_round;
	pfd_pkg::cell_t             data_d;

	assign ready_up = !valid_q || ready_dn;
	assign f_round  = freq_hz + pfd_pkg::ROUND_ADD;

	always_comb begin
		data_d      = '0;
		data_d.rem  = pfd_pkg::REM_W'(f_round[pfd_pkg::FREQ_W-1 -: pfd_pkg::PRE_BITS]);
		data_d.word = {f_round[pfd_pkg::INT_STEPS-1:0], {pfd_pkg::FRAC_BITS{1'b0}}};
		// Band comes from the unrounded frequency
		priority if (freq_hz < pfd_pkg::EDGE_A) begin
			data_d.band = pfd_pkg::BAND_LOW;
			data_d.lna  = 1'b0;
		end else if (freq_hz < pfd_pkg::EDGE_B) begin
			data_d.band = pfd_pkg::BAND_MID;
			data_d.lna  = 1'b0;
		end else if (freq_hz < pfd_pkg::EDGE_C) begin
			data_d.band = pfd_pkg::BAND_HIGH;
			data_d.lna  = 1'b1;
		end else begin
			data_d.band = pfd_pkg::BAND_TOP;
			data_d.lna  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_up) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && in_valid) begin
			data_q <= data_d;
		end
	end

endmodule

### rtl/core/pfd_cell.sv
// pfd_cell: one restoring-division step. Shifts one bit into the remainder,
// compares with the reference and emits one quotient bit. Depends on pfd_pkg.
module pfd_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  pfd_pkg::cell_t in_data,
	output logic           ready_up,
	input  logic           ready_dn,
	output logic           valid_q,
	output pfd_pkg::cell_t data_q
);

	logic [pfd_pkg::REM_W:0] trial;
	logic [pfd_pkg::REM_W:0] ref_ext;
	logic                    qbit;
	pfd_pkg::cell_t          data_d;

	assign ready_up = !valid_q || ready_dn;
	assign trial    = {in_data.rem, in_data.word[pfd_pkg::WORD_W-1]};
	assign ref_ext  = (pfd_pkg::REM_W+1)'(pfd_pkg::REF_HZ);
	assign qbit     = (trial >= ref_ext);

	always_comb begin
		data_d      = in_data;
		data_d.word = {in_data.word[pfd_pkg::WORD_W-2:0], qbit};
		if (qbit) begin
			data_d.rem = pfd_pkg::REM_W'(trial - ref_ext);
		end else begin
			data_d.rem = trial[pfd_pkg::REM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_up) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && in_valid) begin
			data_q <= data_d;
		end
	end

endmodule

### tb/pfd_tb_pkg.sv
`timescale 1ns / 100ps
// pfd_tb_pkg: expected tuning word type, divider predictor and the in-order
// tracker that checks results. Depends on pfd_pkg for the band codes.
package pfd_tb_pkg;

	localparam logic [31:0] REF_CLK_HZ = 32'd30000000;
	localparam logic [31:0] BAND1_HZ   = 32'd2400000000;
	localparam logic [31:0] BAND2_HZ   = 32'd2500000000;
	localparam logic [31:0] BAND3_HZ   = 32'd2600000000;
	localparam logic [31:0] HALF_STEP  = REF_CLK_HZ >> 21;   // 14 Hz
	localparam int          FRAC_W     = 20;

	typedef struct packed {
		logic [1:0] band;
		logic       lna;
		logic [6:0] int_div;
		logic [9:0] frac_hi;
		logic [9:0] frac_lo;
	} tuning_t;

	function automatic tuning_t tuning_words_for(logic [31:0] freq);
		tuning_t     t;
		logic [31:0] rounded;
		logic [31:0] quo;
		logic [31:0] rem;
		logic [19:0] frac;
		if (freq < BAND1_HZ) begin
			t.band = pfd_pkg::BAND_LOW;
			t.lna  = 1'b0;
		end else if (freq < BAND2_HZ) begin
			t.band = pfd_pkg::BAND_MID;
			t.lna  = 1'b0;
		end else if (freq < BAND3_HZ) begin
			t.band = pfd_pkg::BAND_HIGH;
			t.lna  = 1'b1;
		end else begin
			t.band = pfd_pkg::BAND_TOP;
			t.lna  = 1'b1;
		end
		rounded = freq + HALF_STEP;   // wraps mod 2^32
		quo     = rounded / REF_CLK_HZ;
		rem     = rounded % REF_CLK_HZ;
		frac    = '0;
		for (int i = 0; i < FRAC_W; i++) begin
			frac = {frac[18:0], 1'b0};
			rem  = rem << 1;
			if (rem >= REF_CLK_HZ) begin
				frac[0] = 1'b1;
				rem     = rem - REF_CLK_HZ;
			end
		end
		t.int_div = quo[6:0];
		t.frac_hi = frac[19:10];
		t.frac_lo = frac[9:0];
		return t;
	endfunction

	class tuning_tracker;
		tuning_t pending_tunings[$];
		int      fail_count;

		function new();
			fail_count = 0;
		endfunction

		function void note_freq(logic [31:0] freq);
			pending_tunings.push_back(tuning_words_for(freq));
		endfunction

		function int remaining();
			return pending_tunings.size();
		endfunction

		function void compare_field(string fname, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
				fail_count++;
			end
		endfunction

		function void check_tuning(tuning_t got);
			tuning_t want;
			if (pending_tunings.size() == 0) begin
				$display("%0t: unexpected output word, expected none actual %h", $time, got);
				fail_count++;
				return;
			end
			want = pending_tunings.pop_front();
			compare_field("band_code", want.band, got.band);
			compare_field("lna_hi", want.lna, got.lna);
			compare_field("int_divider", want.int_div, got.int_div);
			compare_field("frac_high", want.frac_hi, got.frac_hi);
			compare_field("frac_low", want.frac_lo, got.frac_lo);
		endfunction
	endclass

endpackage

### tb/tb_pll_fractional_divider_calc.sv
`timescale 1ns / 100ps
// tb_pll_fractional_divider_calc: drives target frequencies into the divider
// calculation pipeline and checks each tuning word in order. Depends on
// pfd_pkg, pfd_tb_pkg and the pll_fractional_divider_calc RTL.
module tb_pll_fractional_divider_calc;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 40;    // pipeline is 30 deep
	localparam int HOLD_CYCLES = 400;   // long output hold-off

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [31:0] freq_hz    = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [1:0]  band_code;
	logic        lna_hi;
	logic [6:0]  int_divider;
	logic [9:0]  frac_high;
	logic [9:0]  frac_low;

	// Idle rates in percent; stall_pct and hold_req are read by the output
	// side, so they only change by nonblocking assignment at a clock edge.
	int   send_idle_pct = 0;
	int   stall_pct     = 0;
	logic hold_req      = 1'b0;
	int   cycles        = 0;

	pfd_tb_pkg::tuning_tracker tracker = new();

	pll_fractional_divider_calc DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.freq_hz    (freq_hz),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.band_code  (band_code),
		.lna_hi     (lna_hi),
		.int_divider(int_divider),
		.frac_high  (frac_high),
		.frac_low   (frac_low)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: ends a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offer one word; it is taken at the first edge with in_stall low.
	// Sampling right after the edge sees the values that held at the edge,
	// since every change here and in the block is nonblocking.
	task automatic send_word(input logic [31:0] f);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		freq_hz  <= f;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.note_freq(f);
	endtask

	// Random frequencies weighted toward the interesting spots: band edges,
	// the band region itself, exact reference multiples (rounding carries
	// into the integer part) and the top of the range (rounding wrap).
	function automatic logic [31:0] pick_freq();
		logic [31:0] edges [4];
		logic [31:0] k;
		edges[0] = pfd_tb_pkg::BAND1_HZ;
		edges[1] = pfd_tb_pkg::BAND2_HZ;
		edges[2] = pfd_tb_pkg::BAND3_HZ;
		edges[3] = 32'hFFFF_FFF2;
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return edges[$urandom_range(0, 3)] + $urandom_range(0, 4000) - 32'd2000;
			2: return $urandom_range(32'd2300000000, 32'd2700000000);
			3: begin
				k = $urandom_range(0, 143);
				return k * pfd_tb_pkg::REF_CLK_HZ + $urandom_range(0, 200) - 32'd100;
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_word(pick_freq());
	endtask

	// Output side: check what was taken at this edge, then pick the next
	// stall. A requested hold-off is counted down here at each edge.
	initial begin : out_side
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				tracker.check_tuning({band_code, lna_hi, int_divider, frac_high, frac_low});
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	initial begin : main
		logic [31:0] directed [$];

		// Band edges on both sides, range ends, rounding wrap at the top,
		// integer wrap at 128 x ref, rounding carry into the integer part.
		directed = '{32'd0, 32'd1, 32'd13, 32'd14, 32'hFFFF_FFFF,
			32'hFFFF_FFF2, 32'hFFFF_FFF1, 32'hFFFF_FFEE,
			32'd2399999999, 32'd2400000000, 32'd2499999999, 32'd2500000000,
			32'd2599999999, 32'd2600000000,
			32'd29999985, 32'd29999986, 32'd30000000,
			32'd3839999985, 32'd3839999986, 32'd3840000000,
			32'hAAAA_AAAA, 32'h5555_5555, 32'd2437500000};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words, no idling.
		foreach (directed[i])
			send_word(directed[i]);

		// Random phases: back to back, sender idle, receiver stalling, both.
		send_random(120);
		send_idle_pct = 69;
		send_random(110);
		send_idle_pct = 0;
		stall_pct <= 69;
		send_random(110);
		send_idle_pct = 31;
		stall_pct <= 31;
		send_random(110);

		// Long hold-off at the output while words keep coming, so the
		// pipeline fills and in_stall has to rise.
		send_idle_pct = 0;
		stall_pct <= 0;
		hold_req  <= 1'b1;
		send_random(100);
		in_valid <= 1'b0;

		while (tracker.remaining() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (tracker.fail_count == 0 && tracker.remaining() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
